[hdl/smsu_pkg.sv]
// Shared types and constants for the modal slosh state update block.
package smsu_pkg;

    // Sample, result and coefficient field widths
    localparam int IN_W    = 16;
    localparam int OUT_W   = 32;
    localparam int COEF_W  = 24;

    // Multiplier digit width (bits of the second operand per cycle)
    localparam int DIG_W   = 16;

    // Configuration port
    localparam int PDATA_W = 64;
    localparam int PADDR_W = 6;
    localparam int RIDX_W  = 3;

    localparam logic [RIDX_W-1:0] REG_A_POS_POS     = 3'd0;
    localparam logic [RIDX_W-1:0] REG_A_POS_VEL     = 3'd1;
    localparam logic [RIDX_W-1:0] REG_A_VEL_POS     = 3'd2;
    localparam logic [RIDX_W-1:0] REG_A_VEL_VEL     = 3'd3;
    localparam logic [RIDX_W-1:0] REG_INPUT_GAIN    = 3'd4;
    localparam logic [RIDX_W-1:0] REG_MOUNT_OFFSET  = 3'd5;
    localparam logic [RIDX_W-1:0] REG_HEIGHT_GAIN   = 3'd6;
    localparam logic [RIDX_W-1:0] REG_PARABOLA      = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_OUT
    } smsu_state_t;

endpackage

[hdl/smsu_mul.sv]
// Sequential signed multiplier, one 16-bit digit of the second operand per cycle.
module smsu_mul #(
    parameter int OP_W = 42
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic signed [OP_W-1:0]     op_a,
    input  logic signed [OP_W-1:0]     op_b,
    output logic                       done,
    output logic signed [2*OP_W-1:0]   product
);
    import smsu_pkg::*;

    localparam int NDIG  = (OP_W + DIG_W - 1) / DIG_W;
    localparam int BM_W  = NDIG * DIG_W;
    localparam int CNT_W = $clog2(NDIG + 1);
    localparam int P_W   = 2 * OP_W;

    logic                       busy_reg;
    logic                       done_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       neg_reg;
    logic [OP_W-1:0]            am_reg;
    logic [BM_W-1:0]            bm_reg;
    logic [P_W-1:0]             acc_reg;
    logic signed [P_W-1:0]      p_reg;
    logic [OP_W+DIG_W-1:0]      part;
    logic [P_W-1:0]             acc_next;
    logic [OP_W-1:0]            a_mag;
    logic [OP_W-1:0]            b_mag;

    always_comb begin
        a_mag    = op_a[OP_W-1] ? OP_W'(-op_a) : OP_W'(op_a);
        b_mag    = op_b[OP_W-1] ? OP_W'(-op_b) : OP_W'(op_b);
        part     = am_reg * bm_reg[BM_W-1 -: DIG_W];
        acc_next = (acc_reg << DIG_W) + P_W'(part);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NDIG);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= op_a[OP_W-1] ^ op_b[OP_W-1];
            am_reg  <= a_mag;
            bm_reg  <= BM_W'(b_mag);
            acc_reg <= '0;
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                p_reg <= neg_reg ? -$signed(acc_reg) : $signed(acc_reg);
            end else begin
                acc_reg <= acc_next;
                bm_reg  <= bm_reg << DIG_W;
            end
        end
    end

    assign done    = done_reg;
    assign product = p_reg;

endmodule

[hdl/smsu_isqrt.sv]
// Bit-serial floor integer square root, one result bit per cycle.
module smsu_isqrt #(
    parameter int RAD_W = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [RAD_W-1:0]     radicand,
    output logic                 done,
    output logic [RAD_W/2-1:0]   root
);
    localparam int RW    = RAD_W / 2;
    localparam int CNT_W = $clog2(RW + 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [RAD_W-1:0]    x_reg;
    logic [RW+2:0]       rem_reg;
    logic [RW-1:0]       root_reg;
    logic [RW+2:0]       rem_sh;
    logic [RW+2:0]       trial;
    logic [RW+2:0]       rem_next;
    logic [RW-1:0]       root_next;

    always_comb begin
        rem_sh = {rem_reg[RW:0], x_reg[RAD_W-1 -: 2]};
        trial  = {1'b0, root_reg, 2'b01};
        if (rem_sh >= trial) begin
            rem_next  = rem_sh - trial;
            root_next = {root_reg[RW-2:0], 1'b1};
        end else begin
            rem_next  = rem_sh;
            root_next = {root_reg[RW-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(RW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            x_reg    <= x_reg << 2;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

[hdl/slosh_modal_state_update.sv]
// Modal slosh state update: top level with sequencer, registers and result stage.
//
// Each accepted item (base acceleration x and y, yaw rate and yaw acceleration,
// Q5.10) corrects the acceleration for rotation at the mount offset, advances
// the x and y modal states (displacement and velocity, Q.16) through the 2x2
// discrete update held in the configuration registers, and returns the new
// state with the slosh height: the height gain times the modal radius plus
// parabola_coeff times yaw rate squared. State and height saturate. The block
// works on one item at a time and drops s_ready from acceptance until the
// result has been taken. It makes 21 passes through the single shared
// multiplier, which handles every product in turn (start, digit steps,
// sign fix-up, done), with the square root of the radius (start, one root
// bit per cycle, done) between the squares and the height products. Stalls
// on m_ready hold the block in its output state. Configuration registers
// sit at byte address 8*index on the APB port; the user must write them
// only while the block is idle, and the block itself does not enforce this.
module slosh_modal_state_update #(
    parameter int STATE_WIDTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input items
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [smsu_pkg::IN_W-1:0]      s_accel_x,
    input  logic signed [smsu_pkg::IN_W-1:0]      s_accel_y,
    input  logic signed [smsu_pkg::IN_W-1:0]      s_yaw_rate,
    input  logic signed [smsu_pkg::IN_W-1:0]      s_yaw_accel,
    // result items
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [smsu_pkg::OUT_W-1:0]     m_disp_x,
    output logic signed [smsu_pkg::OUT_W-1:0]     m_vel_x,
    output logic signed [smsu_pkg::OUT_W-1:0]     m_disp_y,
    output logic signed [smsu_pkg::OUT_W-1:0]     m_vel_y,
    output logic [smsu_pkg::OUT_W-1:0]            m_slosh_height,
    // APB configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [smsu_pkg::PADDR_W-1:0]          paddr,
    input  logic [smsu_pkg::PDATA_W-1:0]          pwdata,
    output logic [smsu_pkg::PDATA_W-1:0]          prdata,
    output logic                                  pready
);
    import smsu_pkg::*;

    // Operand width covers the state, the corrected acceleration and the root
    localparam int U_W   = 40;
    localparam int OP_W  = ((STATE_WIDTH > U_W) ? STATE_WIDTH : U_W) + 2;
    localparam int ACC_W = 2 * OP_W;
    localparam int RAD_W = 2 * STATE_WIDTH;
    localparam int W2_W  = 2 * IN_W;

    // Sequencer steps, one multiplier pass each
    localparam logic [4:0] STEP_W2     = 5'd0;   // w^2
    localparam logic [4:0] STEP_AR_X   = 5'd1;   // ax - alpha*ry
    localparam logic [4:0] STEP_WR_X   = 5'd2;   // - w^2*rx
    localparam logic [4:0] STEP_AR_Y   = 5'd3;   // ay + alpha*rx
    localparam logic [4:0] STEP_WR_Y   = 5'd4;   // - w^2*ry
    localparam logic [4:0] STEP_AXIS_X = 5'd5;   // six steps, x axis rows
    localparam logic [4:0] STEP_AXIS_Y = 5'd11;  // six steps, y axis rows
    localparam logic [4:0] STEP_SQ_X   = 5'd17;  // dx^2
    localparam logic [4:0] STEP_SQ_Y   = 5'd18;  // + dy^2
    localparam logic [4:0] STEP_HC     = 5'd19;  // height gain * radius
    localparam logic [4:0] STEP_PC     = 5'd20;  // + parabola_coeff * w^2

    // Configuration registers
    logic signed [COEF_W-1:0]   a_pp_reg;
    logic signed [COEF_W-1:0]   a_pv_reg;
    logic signed [COEF_W-1:0]   a_vp_reg;
    logic signed [COEF_W-1:0]   a_vv_reg;
    logic [2*COEF_W-1:0]        gain_pair_reg;
    logic [2*IN_W-1:0]          offset_pair_reg;
    logic [COEF_W-1:0]          hgt_gain_reg;
    logic [COEF_W-1:0]          parabola_reg;

    logic signed [COEF_W-1:0]   gain_d;
    logic signed [COEF_W-1:0]   gain_v;
    logic signed [IN_W-1:0]     off_x;
    logic signed [IN_W-1:0]     off_y;

    // Control
    smsu_state_t                state_reg;
    smsu_state_t                state_next;
    logic [4:0]                 step_reg;
    logic [4:0]                 step_next;
    logic                       mul_start;
    logic                       mul_done;
    logic                       sqrt_start;
    logic                       sqrt_done;
    logic                       mul_fire;

    // Latched item
    logic signed [IN_W-1:0]     accel_x_reg;
    logic signed [IN_W-1:0]     accel_y_reg;
    logic signed [IN_W-1:0]     yaw_rate_reg;
    logic signed [IN_W-1:0]     yaw_accel_reg;

    // Working values and modal state
    logic [W2_W-1:0]            w2_reg;
    logic signed [U_W-1:0]      ucx_reg;
    logic signed [U_W-1:0]      ucy_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [STATE_WIDTH-1:0] nd_reg;
    logic signed [STATE_WIDTH-1:0] dx_reg;
    logic signed [STATE_WIDTH-1:0] vx_reg;
    logic signed [STATE_WIDTH-1:0] dy_reg;
    logic signed [STATE_WIDTH-1:0] vy_reg;
    logic [RAD_W-1:0]           sq_reg;
    logic [STATE_WIDTH-1:0]     root;

    // Result stage
    logic signed [OUT_W-1:0]    m_disp_x_reg;
    logic signed [OUT_W-1:0]    m_vel_x_reg;
    logic signed [OUT_W-1:0]    m_disp_y_reg;
    logic signed [OUT_W-1:0]    m_vel_y_reg;
    logic [OUT_W-1:0]           m_height_reg;

    // Shared multiplier datapath
    logic signed [OP_W-1:0]     op_a;
    logic signed [OP_W-1:0]     op_b;
    logic signed [ACC_W-1:0]    mul_p;
    logic signed [ACC_W-1:0]    p_sh;
    logic signed [ACC_W-1:0]    base;
    logic signed [ACC_W-1:0]    sum;
    logic                       neg_term;
    logic                       axis_y;
    logic [2:0]                 row;
    logic signed [STATE_WIDTH-1:0] cur_d;
    logic signed [STATE_WIDTH-1:0] cur_v;
    logic signed [U_W-1:0]      cur_u;
    logic [STATE_WIDTH-1:0]     mag_dx;
    logic [STATE_WIDTH-1:0]     mag_dy;

    function automatic logic signed [STATE_WIDTH-1:0] sat_st(
        input logic signed [ACC_W-1:0] x
    );
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = {{(ACC_W-STATE_WIDTH+1){1'b0}}, {(STATE_WIDTH-1){1'b1}}};
        lo = ~hi;
        if (x > hi) begin
            return hi[STATE_WIDTH-1:0];
        end else if (x < lo) begin
            return lo[STATE_WIDTH-1:0];
        end
        return x[STATE_WIDTH-1:0];
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_out(
        input logic signed [STATE_WIDTH-1:0] s
    );
        logic signed [ACC_W-1:0] x;
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        x  = ACC_W'(s);
        hi = {{(ACC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
        lo = ~hi;
        if (x > hi) begin
            return hi[OUT_W-1:0];
        end else if (x < lo) begin
            return lo[OUT_W-1:0];
        end
        return x[OUT_W-1:0];
    endfunction

    function automatic logic [STATE_WIDTH-1:0] mag(
        input logic signed [STATE_WIDTH-1:0] s
    );
        return s[STATE_WIDTH-1] ? STATE_WIDTH'(-s) : STATE_WIDTH'(s);
    endfunction

    assign gain_d = $signed(gain_pair_reg[COEF_W-1:0]);
    assign gain_v = $signed(gain_pair_reg[2*COEF_W-1:COEF_W]);
    assign off_x  = $signed(offset_pair_reg[IN_W-1:0]);
    assign off_y  = $signed(offset_pair_reg[2*IN_W-1:IN_W]);

    // ---------------------------------------------------------------
    // APB register file; write completes on the access cycle
    // ---------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_pp_reg         <= COEF_W'(24'sd4194304);
            a_pv_reg         <= '0;
            a_vp_reg         <= '0;
            a_vv_reg         <= COEF_W'(24'sd4194304);
            gain_pair_reg    <= '0;
            offset_pair_reg  <= '0;
            hgt_gain_reg     <= '0;
            parabola_reg     <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[PADDR_W-1 -: RIDX_W])
                REG_A_POS_POS:    a_pp_reg         <= pwdata[COEF_W-1:0];
                REG_A_POS_VEL:    a_pv_reg         <= pwdata[COEF_W-1:0];
                REG_A_VEL_POS:    a_vp_reg         <= pwdata[COEF_W-1:0];
                REG_A_VEL_VEL:    a_vv_reg         <= pwdata[COEF_W-1:0];
                REG_INPUT_GAIN:   gain_pair_reg    <= pwdata[2*COEF_W-1:0];
                REG_MOUNT_OFFSET: offset_pair_reg  <= pwdata[2*IN_W-1:0];
                REG_HEIGHT_GAIN:  hgt_gain_reg     <= pwdata[COEF_W-1:0];
                REG_PARABOLA:     parabola_reg     <= pwdata[COEF_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[PADDR_W-1 -: RIDX_W])
            REG_A_POS_POS:    prdata = PDATA_W'($unsigned(a_pp_reg));
            REG_A_POS_VEL:    prdata = PDATA_W'($unsigned(a_pv_reg));
            REG_A_VEL_POS:    prdata = PDATA_W'($unsigned(a_vp_reg));
            REG_A_VEL_VEL:    prdata = PDATA_W'($unsigned(a_vv_reg));
            REG_INPUT_GAIN:   prdata = PDATA_W'(gain_pair_reg);
            REG_MOUNT_OFFSET: prdata = PDATA_W'(offset_pair_reg);
            REG_HEIGHT_GAIN:  prdata = PDATA_W'(hgt_gain_reg);
            REG_PARABOLA:     prdata = PDATA_W'(parabola_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_W2;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        mul_start  = 1'b0;
        sqrt_start = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    step_next  = STEP_W2;
                    state_next = ST_MUL_GO;
                end
            end
            ST_MUL_GO: begin
                mul_start  = 1'b1;
                state_next = ST_MUL_WAIT;
            end
            ST_MUL_WAIT: begin
                if (mul_done) begin
                    if (step_reg == STEP_SQ_Y) begin
                        state_next = ST_SQRT_GO;
                    end else if (step_reg == STEP_PC) begin
                        state_next = ST_OUT;
                    end else begin
                        step_next  = step_reg + 5'd1;
                        state_next = ST_MUL_GO;
                    end
                end
            end
            ST_SQRT_GO: begin
                sqrt_start = 1'b1;
                state_next = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT: begin
                if (sqrt_done) begin
                    step_next  = STEP_HC;
                    state_next = ST_MUL_GO;
                end
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign mul_fire = (state_reg == ST_MUL_WAIT) && mul_done;

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            accel_x_reg   <= s_accel_x;
            accel_y_reg   <= s_accel_y;
            yaw_rate_reg  <= s_yaw_rate;
            yaw_accel_reg <= s_yaw_accel;
        end
    end

    // ---------------------------------------------------------------
    // Operand selection and accumulate; each step is
    // sum = base +/- (product >>> shift), floor by arithmetic shift.
    // The w^2*r terms are floored first and then subtracted.
    // ---------------------------------------------------------------
    always_comb begin
        axis_y = (step_reg >= STEP_AXIS_Y);
        row    = 3'(step_reg - (axis_y ? STEP_AXIS_Y : STEP_AXIS_X));
        cur_d  = axis_y ? dy_reg : dx_reg;
        cur_v  = axis_y ? vy_reg : vx_reg;
        cur_u  = axis_y ? ucy_reg : ucx_reg;
        mag_dx = mag(dx_reg);
        mag_dy = mag(dy_reg);

        op_a     = '0;
        op_b     = '0;
        base     = '0;
        p_sh     = mul_p;
        neg_term = 1'b0;
        case (step_reg)
            STEP_W2: begin
                op_a = OP_W'(yaw_rate_reg);
                op_b = OP_W'(yaw_rate_reg);
            end
            STEP_AR_X: begin
                op_a = -OP_W'(yaw_accel_reg);
                op_b = OP_W'(off_y);
                base = ACC_W'(accel_x_reg) <<< 12;
            end
            STEP_WR_X: begin
                op_a     = OP_W'(w2_reg);
                op_b     = OP_W'(off_x);
                base     = acc_reg;
                p_sh     = mul_p >>> 10;
                neg_term = 1'b1;
            end
            STEP_AR_Y: begin
                op_a = OP_W'(yaw_accel_reg);
                op_b = OP_W'(off_x);
                base = ACC_W'(accel_y_reg) <<< 12;
            end
            STEP_WR_Y: begin
                op_a     = OP_W'(w2_reg);
                op_b     = OP_W'(off_y);
                base     = acc_reg;
                p_sh     = mul_p >>> 10;
                neg_term = 1'b1;
            end
            STEP_SQ_X: begin
                op_a = OP_W'(mag_dx);
                op_b = OP_W'(mag_dx);
            end
            STEP_SQ_Y: begin
                op_a = OP_W'(mag_dy);
                op_b = OP_W'(mag_dy);
                base = acc_reg;
            end
            STEP_HC: begin
                op_a = OP_W'(hgt_gain_reg);
                op_b = OP_W'(root);
                p_sh = mul_p >>> 16;
            end
            STEP_PC: begin
                op_a = OP_W'(parabola_reg);
                op_b = OP_W'(w2_reg);
                base = acc_reg;
                p_sh = mul_p >>> 28;
            end
            default: begin
                // state update rows: d' then v', three products each
                case (row)
                    3'd0: begin
                        op_a = OP_W'(a_pp_reg);
                        op_b = OP_W'(cur_d);
                        p_sh = mul_p >>> 22;
                    end
                    3'd1: begin
                        op_a = OP_W'(a_pv_reg);
                        op_b = OP_W'(cur_v);
                        base = acc_reg;
                        p_sh = mul_p >>> 22;
                    end
                    3'd2: begin
                        op_a = OP_W'(gain_d);
                        op_b = OP_W'(cur_u);
                        base = acc_reg;
                        p_sh = mul_p >>> 28;
                    end
                    3'd3: begin
                        op_a = OP_W'(a_vp_reg);
                        op_b = OP_W'(cur_d);
                        p_sh = mul_p >>> 22;
                    end
                    3'd4: begin
                        op_a = OP_W'(a_vv_reg);
                        op_b = OP_W'(cur_v);
                        base = acc_reg;
                        p_sh = mul_p >>> 22;
                    end
                    default: begin
                        op_a = OP_W'(gain_v);
                        op_b = OP_W'(cur_u);
                        base = acc_reg;
                        p_sh = mul_p >>> 28;
                    end
                endcase
            end
        endcase
        sum = neg_term ? (base - p_sh) : (base + p_sh);
    end

    // Modal state, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dx_reg <= '0;
            vx_reg <= '0;
            dy_reg <= '0;
            vy_reg <= '0;
        end else if (mul_fire && step_reg >= STEP_AXIS_X && step_reg < STEP_SQ_X
                     && row == 3'd5) begin
            // velocity row done: commit both halves of the axis
            if (axis_y) begin
                dy_reg <= nd_reg;
                vy_reg <= sat_st(sum);
            end else begin
                dx_reg <= nd_reg;
                vx_reg <= sat_st(sum);
            end
        end
    end

    // Working registers and result stage
    always_ff @(posedge aclk) begin
        if (mul_fire) begin
            acc_reg <= sum;
            case (step_reg)
                STEP_W2:   w2_reg  <= sum[W2_W-1:0];
                STEP_WR_X: ucx_reg <= sum[U_W-1:0];
                STEP_WR_Y: ucy_reg <= sum[U_W-1:0];
                STEP_SQ_Y: sq_reg  <= sum[RAD_W-1:0];
                STEP_PC: begin
                    m_disp_x_reg <= sat_out(dx_reg);
                    m_vel_x_reg  <= sat_out(vx_reg);
                    m_disp_y_reg <= sat_out(dy_reg);
                    m_vel_y_reg  <= sat_out(vy_reg);
                    m_height_reg <= (|sum[ACC_W-1:OUT_W]) ? '1 : sum[OUT_W-1:0];
                end
                default: begin
                    if (step_reg >= STEP_AXIS_X && step_reg < STEP_SQ_X && row == 3'd2) begin
                        nd_reg <= sat_st(sum);
                    end
                end
            endcase
        end
    end

    assign m_disp_x       = m_disp_x_reg;
    assign m_vel_x        = m_vel_x_reg;
    assign m_disp_y       = m_disp_y_reg;
    assign m_vel_y        = m_vel_y_reg;
    assign m_slosh_height = m_height_reg;

    // ---------------------------------------------------------------
    // Shared units
    // ---------------------------------------------------------------
    smsu_mul #(
        .OP_W (OP_W)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (op_a),
        .op_b    (op_b),
        .done    (mul_done),
        .product (mul_p)
    );

    smsu_isqrt #(
        .RAD_W (RAD_W)
    ) u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sq_reg),
        .done     (sqrt_done),
        .root     (root)
    );

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_mul_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> state_reg == ST_MUL_WAIT)
        else $error("multiplier result outside wait state");

    a_sqrt_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        sqrt_done |-> state_reg == ST_SQRT_WAIT)
        else $error("square root result outside wait state");

    a_mul_not_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start |=> !mul_done)
        else $error("multiplier finished the cycle after start");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !m_valid && !s_ready)
        else $error("item accepted while another in flight");

endmodule

[verif/smsu_checker.sv]
// Checker for the modal slosh block: watches the channels and APB, predicts, compares.
module smsu_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic signed [smsu_pkg::IN_W-1:0]    s_accel_x,
    input  logic signed [smsu_pkg::IN_W-1:0]    s_accel_y,
    input  logic signed [smsu_pkg::IN_W-1:0]    s_yaw_rate,
    input  logic signed [smsu_pkg::IN_W-1:0]    s_yaw_accel,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [smsu_pkg::OUT_W-1:0]   m_disp_x,
    input  logic signed [smsu_pkg::OUT_W-1:0]   m_vel_x,
    input  logic signed [smsu_pkg::OUT_W-1:0]   m_disp_y,
    input  logic signed [smsu_pkg::OUT_W-1:0]   m_vel_y,
    input  logic [smsu_pkg::OUT_W-1:0]          m_slosh_height,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [smsu_pkg::PADDR_W-1:0]        paddr,
    input  logic [smsu_pkg::PDATA_W-1:0]        pwdata,
    input  logic                                pready,
    output int                                  pending,
    output int                                  fail_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import smsu_pkg::*;

    typedef struct packed {
        logic signed [OUT_W-1:0] disp_x;
        logic signed [OUT_W-1:0] vel_x;
        logic signed [OUT_W-1:0] disp_y;
        logic signed [OUT_W-1:0] vel_y;
        logic [OUT_W-1:0]        height;
    } slosh_out_t;

    slosh_out_t   slosh_q[$];
    logic [47:0]  coeff[8];
    longint       dx, vx, dy, vy;

    function automatic int reg_bits(input int idx);
        case (idx)
            REG_INPUT_GAIN:   return 48;
            REG_MOUNT_OFFSET: return 32;
            default:          return COEF_W;
        endcase
    endfunction

    function automatic longint sat32(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint unsigned abs64(input longint x);
        return x < 0 ? longint'(-x) : x;
    endfunction

    // one row pair of the 2x2 update, same matrix for both axes
    task automatic step_axis(inout longint d, inout longint v, input longint u);
        longint app, apv, avp, avv, gd, gv, nd, nv;
        app = longint'($signed(coeff[REG_A_POS_POS][23:0]));
        apv = longint'($signed(coeff[REG_A_POS_VEL][23:0]));
        avp = longint'($signed(coeff[REG_A_VEL_POS][23:0]));
        avv = longint'($signed(coeff[REG_A_VEL_VEL][23:0]));
        gd  = longint'($signed(coeff[REG_INPUT_GAIN][23:0]));
        gv  = longint'($signed(coeff[REG_INPUT_GAIN][47:24]));
        nd = ((app * d) >>> 22) + ((apv * v) >>> 22) + ((gd * u) >>> 28);
        nv = ((avp * d) >>> 22) + ((avv * v) >>> 22) + ((gv * u) >>> 28);
        d = sat32(nd);
        v = sat32(nv);
    endtask

    task automatic predict_slosh(input longint ax, input longint ay, input longint w,
                                 input longint alpha);
        longint rx, ry, w2, ucx, ucy;
        longint unsigned sq, rad, c, hc, pc, ht;
        slosh_out_t res;
        rx = longint'($signed(coeff[REG_MOUNT_OFFSET][15:0]));
        ry = longint'($signed(coeff[REG_MOUNT_OFFSET][31:16]));
        w2 = w * w;
        ucx = ax * 4096 - alpha * ry - ((w2 * rx) >>> 10);
        ucy = ay * 4096 + alpha * rx - ((w2 * ry) >>> 10);
        step_axis(dx, vx, ucx);
        step_axis(dy, vy, ucy);
        sq = abs64(dx) * abs64(dx) + abs64(dy) * abs64(dy);
        rad = 0;
        for (int b = 31; b >= 0; b--) begin
            c = rad | (64'd1 << b);
            if (c * c <= sq) rad = c;
        end
        hc = coeff[REG_HEIGHT_GAIN][23:0];
        pc = coeff[REG_PARABOLA][23:0];
        ht = hc * (rad >> 16) + ((hc * (rad & 64'hFFFF)) >> 16) + ((pc * w2) >> 28);
        if (ht > 64'hFFFF_FFFF) ht = 64'hFFFF_FFFF;
        res.disp_x = dx[31:0];
        res.vel_x  = vx[31:0];
        res.disp_y = dy[31:0];
        res.vel_y  = vy[31:0];
        res.height = ht[31:0];
        slosh_q.push_back(res);
    endtask

    task automatic report(input string fld, input logic [31:0] exp_v, input logic [31:0] got_v);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch %s: expected %h got %h at %0t", fld, exp_v, got_v, $realtime);
    endtask

    always @(posedge aclk) begin
        slosh_out_t exp_r;
        int idx;
        if (!aresetn) begin
            coeff[0] = 48'd4194304; coeff[1] = 0; coeff[2] = 0; coeff[3] = 48'd4194304;
            coeff[4] = 0; coeff[5] = 0; coeff[6] = 0; coeff[7] = 0;
            dx = 0; vx = 0; dy = 0; vy = 0;
            slosh_q.delete();
            fail_count = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                idx = int'(paddr >> 3);
                if (idx < 8)
                    coeff[idx] = pwdata[47:0] & ((48'd1 << reg_bits(idx)) - 48'd1)
                                 | (reg_bits(idx) == 48 ? pwdata[47:0] : 48'd0);
            end
            if (m_valid && m_ready) begin
                if (slosh_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result item at %0t", $realtime);
                end else begin
                    exp_r = slosh_q.pop_front();
                    if (m_disp_x !== exp_r.disp_x) report("disp_x", exp_r.disp_x, m_disp_x);
                    if (m_vel_x  !== exp_r.vel_x)  report("vel_x",  exp_r.vel_x,  m_vel_x);
                    if (m_disp_y !== exp_r.disp_y) report("disp_y", exp_r.disp_y, m_disp_y);
                    if (m_vel_y  !== exp_r.vel_y)  report("vel_y",  exp_r.vel_y,  m_vel_y);
                    if (m_slosh_height !== exp_r.height)
                        report("slosh_height", exp_r.height, m_slosh_height);
                end
            end
            if (s_valid && s_ready)
                predict_slosh(s_accel_x, s_accel_y, s_yaw_rate, s_yaw_accel);
        end
        pending = slosh_q.size();
    end

endmodule

[verif/tb_top.sv]
// Top of the modal slosh testbench: clock, reset, stimulus, configuration and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import smsu_pkg::*;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic signed [IN_W-1:0]   s_accel_x = '0, s_accel_y = '0;
    logic signed [IN_W-1:0]   s_yaw_rate = '0, s_yaw_accel = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [OUT_W-1:0]  m_disp_x, m_vel_x, m_disp_y, m_vel_y;
    logic [OUT_W-1:0]         m_slosh_height;
    logic                     psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_W-1:0]       paddr = '0;
    logic [PDATA_W-1:0]       pwdata = '0;
    logic [PDATA_W-1:0]       prdata;
    logic                     pready;
    int                       pending, fail_count;

    // idling switches, flipped per phase so some stretches run flat out
    bit                       tx_gaps = 1'b1;
    bit                       rx_stalls = 1'b1;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    slosh_modal_state_update #(.STATE_WIDTH(32)) u_dut (.*);

    smsu_checker u_chk (.*);

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // result side back-pressure
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                hold--;
            end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                hold = gap_len();
            end else begin
                m_ready <= 1'b1;
                hold = $urandom_range(0, 5);
            end
        end
    end

    // APB write: setup then access; junk above the register width must be dropped
    task automatic apb_write(input logic [RIDX_W-1:0] idx, input logic [47:0] val);
        logic [PDATA_W-1:0] junk;
        logic [PDATA_W-1:0] keep;
        junk = {$urandom, $urandom};
        case (idx)
            REG_INPUT_GAIN:   keep = 64'h0000_FFFF_FFFF_FFFF;
            REG_MOUNT_OFFSET: keep = 64'h0000_0000_FFFF_FFFF;
            default:          keep = 64'h0000_0000_00FF_FFFF;
        endcase
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx) << 3;
        pwdata  <= (junk & ~keep) | ({16'h0, val} & keep);
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_coeffs(input logic [23:0] app, input logic [23:0] apv,
                               input logic [23:0] avp, input logic [23:0] avv,
                               input logic [47:0] gains, input logic [31:0] offs,
                               input logic [23:0] hc, input logic [23:0] pc);
        apb_write(REG_A_POS_POS, {24'h0, app});
        apb_write(REG_A_POS_VEL, {24'h0, apv});
        apb_write(REG_A_VEL_POS, {24'h0, avp});
        apb_write(REG_A_VEL_VEL, {24'h0, avv});
        apb_write(REG_INPUT_GAIN, gains);
        apb_write(REG_MOUNT_OFFSET, {16'h0, offs});
        apb_write(REG_HEIGHT_GAIN, {24'h0, hc});
        apb_write(REG_PARABOLA, {24'h0, pc});
    endtask

    // a damped oscillator-ish matrix with random gains, offsets and height factors
    task automatic load_random_coeffs();
        load_coeffs(24'(4194304 - $urandom_range(0, 40000)),
                    24'($urandom_range(0, 200000)),
                    24'(-$urandom_range(0, 200000)),
                    24'(4194304 - $urandom_range(0, 60000)),
                    48'({$urandom, $urandom}),
                    $urandom, 24'($urandom), 24'($urandom));
    endtask

    // hold valid, payload steady until the item goes through
    task automatic send_sample(input logic [15:0] ax, input logic [15:0] ay,
                               input logic [15:0] w, input logic [15:0] al);
        int g;
        g = tx_gaps ? gap_len() : 0;
        @(negedge aclk);
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_accel_x   <= ax;
        s_accel_y   <= ay;
        s_yaw_rate  <= w;
        s_yaw_accel <= al;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_random(input int n);
        logic [15:0] f[4];
        for (int i = 0; i < n; i++) begin
            foreach (f[k]) begin
                // small magnitudes keep the state in range more often
                if ($urandom_range(0, 3) == 0) f[k] = 16'($signed($urandom_range(0, 2048)) - 1024);
                else f[k] = 16'($urandom);
            end
            send_sample(f[0], f[1], f[2], f[3]);
        end
    endtask

    // drop valid, let every result arrive, then give the block time to settle
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
    endtask

    initial begin
        logic [15:0] ext[3];
        ext[0] = 16'h7FFF; ext[1] = 16'h8000; ext[2] = 16'h0000;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // unconfigured block: identity matrix, zero gains, state stays at zero
        send_sample(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        send_sample(16'h1234, 16'hFEDC, 16'h0400, 16'hFC00);
        drain();

        // directed extremes on a moderate setting, offsets at both ends
        load_coeffs(24'd4190000, 24'd40000, -24'sd40000, 24'd4180000,
                    {24'd300000, 24'd200000}, {16'h7FFF, 16'h8000},
                    24'hFFFFFF, 24'hFFFFFF);
        foreach (ext[i]) foreach (ext[j])
            send_sample(ext[i], ext[j], ext[j], ext[i]);
        send_sample(16'h0000, 16'h0000, 16'h7FFF, 16'h0000);
        send_sample(16'h0000, 16'h0000, 16'h8000, 16'h7FFF);
        drain();

        // full scale matrix and gains: state and height pile into saturation
        load_coeffs(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                    48'h7FFFFF_7FFFFF, 32'h7FFF_7FFF, 24'hFFFFFF, 24'hFFFFFF);
        send_random(12);
        drain();
        load_coeffs(24'h800000, 24'h800000, 24'h800000, 24'h800000,
                    48'h800000_800000, 32'h8000_8000, 24'h000001, 24'h000000);
        send_random(12);
        drain();

        // random settings, idling pattern varies phase by phase
        for (int p = 0; p < 8; p++) begin
            tx_gaps   = (p % 3) != 1;
            rx_stalls = (p % 3) != 2;
            if (p == 5)
                load_coeffs(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                            48'({$urandom, $urandom}), $urandom,
                            24'($urandom), 24'd0);
            else
                load_random_coeffs();
            send_random(95);
            drain();
        end

        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

[slosh_modal_state_update.f]
hdl/smsu_pkg.sv
hdl/smsu_mul.sv
hdl/smsu_isqrt.sv
hdl/slosh_modal_state_update.sv
verif/smsu_checker.sv
verif/tb_top.sv
